FILE: rtl/core/vmcs_pkg.sv
// ----------------------------------------------------------------------------
// vmcs_pkg
// shared constants, types and the field code tables of the shadow cache
// ----------------------------------------------------------------------------
package vmcs_pkg;

    localparam int GP_SLOTS      = 15;
    localparam int WIDE_SLOTS    = 34;
    localparam int NATURAL_SLOTS = 26;
    localparam int WORD_SLOTS    = 46;
    localparam int HALF_SLOTS    = 12;

    localparam int WIDE_BASE   = GP_SLOTS;
    localparam int NAT_BASE    = WIDE_BASE + WIDE_SLOTS;
    localparam int WORD_BASE   = NAT_BASE + NATURAL_SLOTS;
    localparam int HALF_BASE   = WORD_BASE + WORD_SLOTS;
    localparam int TOTAL_SLOTS = HALF_BASE + HALF_SLOTS;
    localparam int IDX_W       = $clog2(TOTAL_SLOTS);
    localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);

    typedef logic [IDX_W-1:0] idx_t;

    localparam logic [2:0] FUNC_READ    = 3'd0;
    localparam logic [2:0] FUNC_WRITE   = 3'd1;
    localparam logic [2:0] FUNC_SET     = 3'd2;
    localparam logic [2:0] FUNC_QUERY   = 3'd3;
    localparam logic [2:0] FUNC_COUNT   = 3'd4;
    localparam logic [2:0] FUNC_COLLECT = 3'd5;
    localparam logic [2:0] FUNC_CLEAR   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNCACHED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    localparam logic REG_GP_BASE  = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    typedef struct packed {
        logic       known;
        logic [IDX_W-1:0] idx;
    } dec_t;

    localparam logic [15:0] WIDE_TAB [34] = '{
        16'h2000, 16'h2002, 16'h2004, 16'h2006, 16'h2008, 16'h200a, 16'h2010,
        16'h2012, 16'h2014, 16'h2016, 16'h201a, 16'h201c, 16'h201e, 16'h2020,
        16'h2022, 16'h202c, 16'h2400, 16'h2800, 16'h2802, 16'h2804, 16'h2806,
        16'h2808, 16'h280a, 16'h280c, 16'h280e, 16'h2810, 16'h2812, 16'h2026,
        16'h2028, 16'h2018, 16'h2024, 16'h200e, 16'h202e, 16'h2032};
    localparam logic [15:0] NAT_TAB [26] = '{
        16'h6000, 16'h6002, 16'h6004, 16'h6006, 16'h6400, 16'h640a, 16'h6800,
        16'h6802, 16'h6804, 16'h6806, 16'h6808, 16'h680a, 16'h680c, 16'h680e,
        16'h6810, 16'h6812, 16'h6814, 16'h6816, 16'h6818, 16'h681a, 16'h681c,
        16'h681e, 16'h6820, 16'h6822, 16'h6824, 16'h6826};
    localparam logic [15:0] WORD_TAB [46] = '{
        16'h4000, 16'h4002, 16'h4004, 16'h4006, 16'h4008, 16'h400a, 16'h400c,
        16'h400e, 16'h4010, 16'h4012, 16'h4014, 16'h4016, 16'h4018, 16'h401a,
        16'h401c, 16'h401e, 16'h4400, 16'h4402, 16'h4404, 16'h4406, 16'h4408,
        16'h440a, 16'h440c, 16'h440e, 16'h4800, 16'h4802, 16'h4804, 16'h4806,
        16'h4808, 16'h480a, 16'h480c, 16'h480e, 16'h4810, 16'h4812, 16'h4814,
        16'h4816, 16'h4818, 16'h481a, 16'h481c, 16'h481e, 16'h4820, 16'h4822,
        16'h4824, 16'h4826, 16'h482a, 16'h482e};
    localparam logic [15:0] HALF_TAB [12] = '{
        16'h0000, 16'h0002, 16'h0800, 16'h0802, 16'h0804, 16'h0806, 16'h0808,
        16'h080a, 16'h080c, 16'h080e, 16'h0810, 16'h0812};

    // code of a slot, general registers from the base register
    function automatic logic [15:0] slot_code(idx_t idx, logic [15:0] base);
        logic [15:0] r;
        int          i;
        begin
            i = int'(idx);
            r = 16'h0;
            if (i < WIDE_BASE)
                r = base + {{(15 - IDX_W){1'b0}}, idx, 1'b0};
            else if (i < NAT_BASE)
                r = WIDE_TAB[i - WIDE_BASE];
            else if (i < WORD_BASE)
                r = NAT_TAB[i - NAT_BASE];
            else if (i < HALF_BASE)
                r = WORD_TAB[i - WORD_BASE];
            else if (i < TOTAL_SLOTS)
                r = HALF_TAB[i - HALF_BASE];
            return r;
        end
    endfunction

    function automatic logic [63:0] slot_mask(idx_t idx);
        logic [63:0] m;
        begin
            m = '1;
            if (int'(idx) >= HALF_BASE)
                m = 64'h0000_0000_0000_ffff;
            else if (int'(idx) >= WORD_BASE)
                m = 64'h0000_0000_ffff_ffff;
            return m;
        end
    endfunction

endpackage

FILE: rtl/core/vmcs_field_shadow_cache.sv
// ----------------------------------------------------------------------------
// vmcs_field_shadow_cache
// shadow store of control fields with per-slot valid and dirty marks
// ----------------------------------------------------------------------------
// read, write, set, query, clear: the request is registered, then its result is
// loaded into the result register; count walks all slots, then gives the sum
// collect: the same walk, plus one result per emitted entry, shorter when the
// capacity ends the walk early; result stalls hold up both
// one request in flight; a new one is taken when idle and the result register is free
// reset clears marks and registers at once; the value memory is not cleared
module vmcs_field_shadow_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // field_code, write_value
    input  logic [3:0]  s_tuser,  // func, clear_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // status, read_value, entry_count, out_field_code
    output logic [1:0]  m_tuser,  // cached
    output logic        m_tlast
);
    import vmcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OP   = 4'b0010,
        S_WALK = 4'b0100,
        S_SUM  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] gp_base_reg;
    logic [5:0]  cap_reg;
    logic [TOTAL_SLOTS-1:0] valid_reg, dirty_reg;
    logic [2:0]  func_reg;
    logic [63:0] wval_reg;
    logic        clrv_reg;
    idx_t        idx_reg;
    logic        known_reg;
    logic [CNT_W-1:0] walk_reg;   // next slot to read in the walk
    logic        walk_hit_reg;
    logic [7:0]  cnt_reg;
    logic        ov_reg;
    logic        out_full_reg;
    logic [1:0]  status_reg;
    logic [63:0] value_reg;
    logic        cached_reg, last_reg;
    logic [7:0]  count_reg;
    logic [15:0] ocode_reg;
    dec_t        dec;
    logic        ram_we;
    idx_t        ram_raddr;
    logic [63:0] ram_rdata;
    logic        take_in, out_free;
    logic        hit_pending, out_load;
    idx_t        walk_prev;

    assign out_free = !out_full_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign take_in  = s_tvalid && s_tready;
    assign hit_pending = walk_hit_reg && func_reg == FUNC_COLLECT;
    assign walk_prev   = idx_t'(walk_reg - 1'b1);

    assign out_load = out_free
        && ((state_reg == S_OP && func_reg != FUNC_COUNT && func_reg != FUNC_COLLECT)
            || (state_reg == S_WALK && hit_pending)
            || state_reg == S_SUM);

    vmcs_decode u_dec (.code(s_tdata[15:0]), .gp_base(gp_base_reg), .dec(dec));

    assign ram_we = (state_reg == S_OP) && known_reg && out_free
        && (func_reg == FUNC_WRITE || func_reg == FUNC_SET)
        && !(valid_reg[idx_reg] && ram_rdata == wval_reg);
    // a pending collected entry keeps its slot on the read port
    assign ram_raddr = take_in ? dec.idx
        : (hit_pending ? walk_prev : idx_t'(walk_reg));

    vmcs_value_ram u_ram (
        .clk(clk), .we(ram_we), .waddr(idx_reg), .wdata(wval_reg & slot_mask(idx_reg)),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {6'd0, ocode_reg, count_reg, value_reg, status_reg};
    assign m_tuser  = {1'b0, cached_reg};
    assign m_tlast  = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (take_in) state_next = S_OP;
            S_OP:
                if (out_free)
                    state_next = (func_reg == FUNC_COUNT || func_reg == FUNC_COLLECT)
                        ? S_WALK : S_IDLE;
            S_WALK:
                if (!hit_pending && (int'(walk_reg) >= TOTAL_SLOTS || ov_reg))
                    state_next = S_SUM;
            S_SUM: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            gp_base_reg  <= 16'd28672;
            cap_reg      <= 6'd63;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            out_full_reg <= 1'b0;
            walk_reg     <= '0;
            walk_hit_reg <= 1'b0;
            cnt_reg      <= '0;
            ov_reg       <= 1'b0;
            func_reg     <= '0;
            clrv_reg     <= 1'b0;
            wval_reg     <= '0;
            idx_reg      <= '0;
            known_reg    <= 1'b0;
            status_reg   <= '0;
            value_reg    <= '0;
            cached_reg   <= 1'b0;
            count_reg    <= '0;
            ocode_reg    <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_full_reg <= out_load || (out_full_reg && !m_tready);
            if (cfg_we)
            begin
                if (cfg_index == REG_GP_BASE)
                    gp_base_reg <= cfg_data;
                else
                    cap_reg <= cfg_data[5:0];
            end
            if (take_in)
            begin
                func_reg  <= s_tuser[2:0];
                clrv_reg  <= s_tuser[3];
                wval_reg  <= s_tdata[79:16];
                idx_reg   <= dec.idx;
                known_reg <= dec.known;
            end
            unique case (state_reg)
                S_OP:
                    if (out_free)
                    begin
                        status_reg <= ST_OK; value_reg <= '0; cached_reg <= 1'b0;
                        count_reg <= '0; ocode_reg <= '0; last_reg <= 1'b1;
                        walk_reg <= '0; walk_hit_reg <= 1'b0; cnt_reg <= '0;
                        ov_reg <= (func_reg == FUNC_COLLECT) && (cap_reg == 6'd0);
                        unique case (func_reg)
                            FUNC_READ:
                                if (!known_reg) status_reg <= ST_UNKNOWN;
                                else if (!valid_reg[idx_reg]) status_reg <= ST_UNCACHED;
                                else value_reg <= ram_rdata;
                            FUNC_WRITE, FUNC_SET:
                                if (!known_reg) status_reg <= ST_UNKNOWN;
                                else if (ram_we)
                                begin
                                    valid_reg[idx_reg] <= 1'b1;
                                    if (func_reg == FUNC_WRITE)
                                        dirty_reg[idx_reg] <= 1'b1;
                                end
                            FUNC_QUERY:
                                if (!known_reg) status_reg <= ST_UNKNOWN;
                                else cached_reg <= valid_reg[idx_reg];
                            FUNC_CLEAR:
                            begin
                                dirty_reg <= '0;
                                if (clrv_reg) valid_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                S_WALK:
                begin
                    // ram_rdata holds the slot read in the cycle before
                    if (hit_pending)
                    begin
                        if (out_free)
                        begin
                            status_reg <= ST_OK; value_reg <= ram_rdata;
                            cached_reg <= 1'b0;
                            count_reg <= '0; last_reg <= 1'b0;
                            ocode_reg <= slot_code(walk_prev, gp_base_reg);
                            cnt_reg <= cnt_reg + 1'b1;
                            ov_reg <= (cnt_reg + 1'b1) >= {2'b0, cap_reg};
                            walk_hit_reg <= 1'b0;
                        end
                    end
                    else if (int'(walk_reg) < TOTAL_SLOTS && !ov_reg)
                    begin
                        walk_hit_reg <= dirty_reg[idx_t'(walk_reg)];
                        if (dirty_reg[idx_t'(walk_reg)] && func_reg == FUNC_COUNT)
                            cnt_reg <= cnt_reg + 1'b1;
                        walk_reg <= walk_reg + 1'b1;
                    end
                end
                S_SUM:
                    if (out_free)
                    begin
                        status_reg <= (func_reg == FUNC_COLLECT && ov_reg)
                            ? ST_CAPACITY : ST_OK;
                        value_reg <= '0; cached_reg <= 1'b0; count_reg <= cnt_reg;
                        ocode_reg <= '0; last_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/core/vmcs_decode.sv
// ----------------------------------------------------------------------------
// vmcs_decode
// field code to slot index decoder
// ----------------------------------------------------------------------------
module vmcs_decode (
    input  logic [15:0]   code,
    input  logic [15:0]   gp_base,
    output vmcs_pkg::dec_t dec
);
    import vmcs_pkg::*;

    logic [16:0] off;

    always_comb
    begin
        off = {1'b0, code} - {1'b0, gp_base};
        dec = '0;
        if (!off[16] && off[15:0] <= 16'(2 * (GP_SLOTS - 1)))
        begin
            dec.known = 1'b1;
            dec.idx   = IDX_W'(off[15:1]);
        end
        else if (!code[0])
        begin
            unique case (code[14:13])
                2'd0:
                    for (int i = 0; i < HALF_SLOTS; i++)
                        if (HALF_TAB[i] == code)
                        begin
                            dec.known = 1'b1;
                            dec.idx   = IDX_W'(HALF_BASE + i);
                        end
                2'd1:
                    for (int i = 0; i < WIDE_SLOTS; i++)
                        if (WIDE_TAB[i] == code)
                        begin
                            dec.known = 1'b1;
                            dec.idx   = IDX_W'(WIDE_BASE + i);
                        end
                2'd2:
                    for (int i = 0; i < WORD_SLOTS; i++)
                        if (WORD_TAB[i] == code)
                        begin
                            dec.known = 1'b1;
                            dec.idx   = IDX_W'(WORD_BASE + i);
                        end
                default:
                    for (int i = 0; i < NATURAL_SLOTS; i++)
                        if (NAT_TAB[i] == code)
                        begin
                            dec.known = 1'b1;
                            dec.idx   = IDX_W'(NAT_BASE + i);
                        end
            endcase
        end
    end

endmodule

FILE: rtl/core/vmcs_value_ram.sv
// ----------------------------------------------------------------------------
// vmcs_value_ram
// slot value store, one write and one registered read port
// ----------------------------------------------------------------------------
module vmcs_value_ram (
    input  logic                 clk,
    input  logic                 we,
    input  vmcs_pkg::idx_t       waddr,
    input  logic [63:0]          wdata,
    input  vmcs_pkg::idx_t       raddr,
    output logic [63:0]          rdata
);
    import vmcs_pkg::*;

    logic [63:0] mem [TOTAL_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/vmcs_checker.sv
// ----------------------------------------------------------------------------
// vmcs_checker
// port level checks of the shadow cache
// ----------------------------------------------------------------------------
module vmcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast
);
    import vmcs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken early");

    a_simple_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[2:0] != FUNC_COUNT
        && s_tuser[2:0] != FUNC_COLLECT |=> ##1 m_tvalid && m_tlast)
        else $error("single result late");

    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[1:0] == ST_OK)
        else $error("collected entry with bad status");
endmodule

bind vmcs_field_shadow_cache vmcs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vmcs_field_shadow_cache. A queue-fed driver sends
// request transfers and a monitor checks every result transfer in order
// against a cycle-free shadow of the slot store. Both sides stall at random.
// The run goes through several base and capacity settings, the base extremes
// and the largest capacity among them, and mixes directed corner requests with random traffic.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmcs_pkg::*;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] code;
        logic [63:0] wval;
        logic        clr_valid;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic        cached;
        logic [7:0]  count;
        logic [15:0] code;
        logic        last;
    } answer_t;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;  // field_code, write_value
    logic [3:0]  s_tuser = '0;  // func, clear_valid
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;       // status, read_value, entry_count, out_field_code
    logic [1:0]  m_tuser;       // cached
    logic        m_tlast;

    request_t    pending_reqs[$];
    answer_t     expected_answers[$];
    request_t    cur_req;

    logic [15:0] gp_base = 16'h7000;
    logic [5:0]  capacity = 6'd63;
    logic [63:0] shadow_val [TOTAL_SLOTS];
    logic        shadow_vld [TOTAL_SLOTS];
    logic        shadow_dirty [TOTAL_SLOTS];
    logic [63:0] last_wval [TOTAL_SLOTS];

    int errors = 0;
    int reqs_sent = 0;
    int answers_seen = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int idle_cycles = 0;

    vmcs_field_shadow_cache dut (.*);

    always #6 clk = ~clk;

    function automatic int decode_slot(logic [15:0] code);
        logic [16:0] off;
        off = {1'b0, code} - {1'b0, gp_base};
        if (code >= gp_base && off <= 17'(2 * (GP_SLOTS - 1)))
            return int'(off >> 1);
        if (code[0])
            return -1;
        case (code[14:13])
            2'd0: for (int i = 0; i < HALF_SLOTS; i++)
                if (HALF_TAB[i] == code) return HALF_BASE + i;
            2'd1: for (int i = 0; i < WIDE_SLOTS; i++)
                if (WIDE_TAB[i] == code) return WIDE_BASE + i;
            2'd2: for (int i = 0; i < WORD_SLOTS; i++)
                if (WORD_TAB[i] == code) return WORD_BASE + i;
            default: for (int i = 0; i < NATURAL_SLOTS; i++)
                if (NAT_TAB[i] == code) return NAT_BASE + i;
        endcase
        return -1;
    endfunction

    function automatic logic [15:0] code_of_slot(int idx);
        if (idx < WIDE_BASE) return gp_base + 16'(2 * idx);
        if (idx < NAT_BASE) return WIDE_TAB[idx - WIDE_BASE];
        if (idx < WORD_BASE) return NAT_TAB[idx - NAT_BASE];
        if (idx < HALF_BASE) return WORD_TAB[idx - WORD_BASE];
        return HALF_TAB[idx - HALF_BASE];
    endfunction

    function automatic logic [63:0] width_mask(int idx);
        if (idx >= HALF_BASE) return 64'hffff;
        if (idx >= WORD_BASE) return 64'hffff_ffff;
        return '1;
    endfunction

    function automatic answer_t one_answer(logic [1:0] st, logic [63:0] v, logic c,
                                           logic [7:0] n, logic [15:0] fc, logic l);
        answer_t a;
        a.status = st;
        a.value = v;
        a.cached = c;
        a.count = n;
        a.code = fc;
        a.last = l;
        return a;
    endfunction

    task automatic predict_answers(request_t r);
        int idx;
        int k;
        int n;
        idx = decode_slot(r.code);
        case (r.func)
            FUNC_READ:
                if (idx < 0)
                    expected_answers.push_back(
                        one_answer(ST_UNKNOWN, '0, 1'b0, '0, '0, 1'b1));
                else if (!shadow_vld[idx])
                    expected_answers.push_back(
                        one_answer(ST_UNCACHED, '0, 1'b0, '0, '0, 1'b1));
                else
                    expected_answers.push_back(
                        one_answer(ST_OK, shadow_val[idx], 1'b0, '0, '0, 1'b1));
            FUNC_WRITE, FUNC_SET:
                if (idx < 0)
                    expected_answers.push_back(
                        one_answer(ST_UNKNOWN, '0, 1'b0, '0, '0, 1'b1));
                else
                begin
                    if (!(shadow_vld[idx] && shadow_val[idx] == r.wval))
                    begin
                        shadow_vld[idx] = 1'b1;
                        if (r.func == FUNC_WRITE)
                            shadow_dirty[idx] = 1'b1;
                        shadow_val[idx] = r.wval & width_mask(idx);
                    end
                    expected_answers.push_back(
                        one_answer(ST_OK, '0, 1'b0, '0, '0, 1'b1));
                end
            FUNC_QUERY:
                if (idx < 0)
                    expected_answers.push_back(
                        one_answer(ST_UNKNOWN, '0, 1'b0, '0, '0, 1'b1));
                else
                    expected_answers.push_back(
                        one_answer(ST_OK, '0, shadow_vld[idx], '0, '0, 1'b1));
            FUNC_COUNT:
            begin
                n = 0;
                for (int i = 0; i < TOTAL_SLOTS; i++)
                    n += shadow_dirty[i];
                expected_answers.push_back(one_answer(ST_OK, '0, 1'b0, 8'(n), '0, 1'b1));
            end
            FUNC_COLLECT:
            begin
                k = 0;
                for (int i = 0; i < TOTAL_SLOTS && k < capacity; i++)
                    if (shadow_dirty[i])
                    begin
                        expected_answers.push_back(one_answer(ST_OK, shadow_val[i], 1'b0,
                                                              '0, code_of_slot(i), 1'b0));
                        k++;
                    end
                expected_answers.push_back(one_answer(k >= capacity ? ST_CAPACITY : ST_OK,
                                                      '0, 1'b0, 8'(k), '0, 1'b1));
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < TOTAL_SLOTS; i++)
                begin
                    shadow_dirty[i] = 1'b0;
                    if (r.clr_valid)
                        shadow_vld[i] = 1'b0;
                end
                expected_answers.push_back(one_answer(ST_OK, '0, 1'b0, '0, '0, 1'b1));
            end
            default:
                expected_answers.push_back(one_answer(ST_OK, '0, 1'b0, '0, '0, 1'b1));
        endcase
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (s_tvalid)
            begin
                predict_answers(cur_req);
                reqs_sent++;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                s_tdata <= {cur_req.wval, cur_req.code};
                s_tuser <= {cur_req.clr_valid, cur_req.func};
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: tdata %h", m_tdata);
                end
                else
                begin
                    exp_a = expected_answers.pop_front();
                    if (m_tdata != {6'b0, exp_a.code, exp_a.count, exp_a.value, exp_a.status}
                        || m_tuser != {1'b0, exp_a.cached} || m_tlast != exp_a.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: exp st %0d val %h cch %0d cnt %0d code %h last %0d",
                                exp_a.status, exp_a.value, exp_a.cached, exp_a.count,
                                exp_a.code, exp_a.last);
                            $display("          act st %0d val %h cch %0d cnt %0d code %h last %0d",
                                m_tdata[1:0], m_tdata[65:2], m_tuser[0], m_tdata[73:66],
                                m_tdata[89:74], m_tlast);
                        end
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic request_t mk(logic [2:0] f, logic [15:0] c, logic [63:0] v,
                                    logic cv);
        request_t r;
        r.func = f;
        r.code = c;
        r.wval = v;
        r.clr_valid = cv;
        return r;
    endfunction

    function automatic logic [15:0] pick_code();
        int p;
        p = $urandom_range(99);
        if (p < 15)
            return gp_base + 16'(2 * $urandom_range(GP_SLOTS - 1)) + 16'($urandom_range(1));
        if (p < 35) return WIDE_TAB[$urandom_range(WIDE_SLOTS - 1)];
        if (p < 52) return NAT_TAB[$urandom_range(NATURAL_SLOTS - 1)];
        if (p < 72) return WORD_TAB[$urandom_range(WORD_SLOTS - 1)];
        if (p < 84) return HALF_TAB[$urandom_range(HALF_SLOTS - 1)];
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] pick_value(logic [15:0] code);
        int idx;
        int p;
        idx = decode_slot(code);
        p = $urandom_range(99);
        if (idx >= 0 && p < 20) return last_wval[idx];
        if (p < 30) return {48'b0, 16'($urandom)};
        if (p < 35) return '1;
        if (p < 40) return '0;
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random(int count);
        int p;
        logic [2:0] f;
        logic [15:0] c;
        logic [63:0] v;
        int idx;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(99);
            if (p < 32) f = FUNC_WRITE;
            else if (p < 46) f = FUNC_SET;
            else if (p < 66) f = FUNC_READ;
            else if (p < 76) f = FUNC_QUERY;
            else if (p < 82) f = FUNC_COUNT;
            else if (p < 92) f = FUNC_COLLECT;
            else if (p < 97) f = FUNC_CLEAR;
            else f = 3'd7;
            c = pick_code();
            v = pick_value(c);
            idx = decode_slot(c);
            if (idx >= 0 && (f == FUNC_WRITE || f == FUNC_SET))
                last_wval[idx] = v;
            pending_reqs.push_back(mk(f, c, v, 1'($urandom)));
        end
    endtask

    task automatic cfg_write(logic idx, logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GP_BASE)
            gp_base = data;
        else
            capacity = data[5:0];
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_answers.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] bases [6];
        logic [5:0]  caps [6];
        for (int i = 0; i < TOTAL_SLOTS; i++)
        begin
            shadow_val[i] = '0;
            shadow_vld[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            last_wval[i] = '0;
        end
        bases = '{16'h7000, 16'h0000, 16'hffff, 16'hffe4, 16'h6000, 16'($urandom)};
        caps = '{6'd63, 6'd1, 6'd5, 6'd63, 6'd2, 6'($urandom_range(63, 1))};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_write(REG_GP_BASE, bases[ph]);
            cfg_write(REG_CAPACITY, 16'(caps[ph]));
            if (ph == 0)
            begin
                pending_reqs.push_back(mk(FUNC_READ, 16'h2000, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_QUERY, 16'h2000, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'h7000, '1, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'h701c, 64'h8000_0000_0000_0001, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'h2032, '1, 1'b0));
                pending_reqs.push_back(mk(FUNC_SET, 16'h6826, 64'h1234_5678_9abc_def0, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'h482e, '1, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'h0812, 64'h0001_0000_0000_abcd, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'h0812, 64'h0001_0000_0000_abcd, 1'b0));
                pending_reqs.push_back(mk(FUNC_SET, 16'h6826, 64'h1234_5678_9abc_def0, 1'b0));
                pending_reqs.push_back(mk(FUNC_READ, 16'h0812, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_READ, 16'h482e, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_READ, 16'h7001, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_READ, 16'h2001, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_WRITE, 16'hffff, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_QUERY, 16'h3000, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_QUERY, 16'h6826, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_COUNT, '0, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_COLLECT, '0, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_CLEAR, '0, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_READ, 16'h2032, '0, 1'b0));
                pending_reqs.push_back(mk(FUNC_CLEAR, '0, '0, 1'b1));
                pending_reqs.push_back(mk(FUNC_READ, 16'h2032, '0, 1'b0));
                pending_reqs.push_back(mk(3'd7, 16'hffff, '1, 1'b1));
                pending_reqs.push_back(mk(FUNC_COLLECT, '0, '0, 1'b0));
            end
            queue_random(ph == 5 ? 70 : 75);
            drain();
        end

        $display("summary: %0d requests and %0d results checked", reqs_sent, answers_seen);
        $display("over 6 base/capacity settings, extremes included");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
